>>> design/uwrap_pkg.sv
// shared types and constants for the utf-8 greedy word wrapper
// used by the front end, the token queue, the back end and the top level
// no dependencies

package uwrap_pkg;

  // default store depth, i.e. the widest line the block supports
  localparam int DEF_MAX_WIDTH = 40;

  // line width register
  localparam int           CFG_W     = 6;
  localparam logic [5:0]   CFG_RESET = 6'd40;

  // token queue depth
  localparam int FIFO_DEPTH = 2;

  // character codes
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  // upper bounds of the lead byte classes
  localparam logic [7:0] LEAD1_MAX = 8'hbf;
  localparam logic [7:0] LEAD2_MAX = 8'hdf;
  localparam logic [7:0] LEAD3_MAX = 8'hef;
  localparam logic [7:0] LEAD4_MAX = 8'hf7;

  // what a byte asks for after its character (if any) is added
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SPACE = 2'd1,
    ACT_NEWL  = 2'd2
  } act_t;

  // one classified input byte, front end to back end
  typedef struct packed {
    logic        ch_valid;  // a complete character is added to the word
    logic [31:0] ch;        // its bytes, first byte lowest
    act_t        act;       // space or newline handling after the character
    logic        fin;       // last byte of the text
  } tok_t;

  // one result, back end to top level
  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  len;
    logic        line_end;
    logic        run_last;
  } res_t;

endpackage

>>> design/utf8_greedy_word_wrap.sv
// top level of the utf-8 greedy word wrapper
// depends on uwrap_pkg, uwrap_front, uwrap_fifo and uwrap_back

// Takes UTF-8 text one byte per transaction (in_tlast marks the last byte)
// and returns one transaction per character placed on a line, plus a mark
// transaction (out_tuser high, no character) that closes each line; out_tlast
// flags the last result caused by an input byte, and a byte may cause none.
// line_width sets the characters per line and is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce it. The front end takes a byte every cycle
// as long as its two-entry token queue has room. The back-end sequencer sets
// the throughput: it takes the next token only from idle, after the last one
// has gone through its states (add, flush, emit, space or newline, end-of-text
// close, done). A word flush or a cut that streams stored characters out of
// the word store, and a line-end mark that comes ahead of a word or ends a cut
// word, lengthen this work; receiver stalls hold up all of these. Bytes inside
// a multibyte character and zero bytes cost the back end nothing. There is no
// clearing pass after reset.

module utf8_greedy_word_wrap #(
  parameter int MAX_WIDTH = uwrap_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [uwrap_pkg::CFG_W-1:0] cfg_wr_data,   // line_width
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,      // [7:0] text_byte
  input  logic                        in_tlast,      // final_byte
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,     // [31:0] char_bytes, [34:32] char_len
  output logic                        out_tuser,     // [0] line_end
  output logic                        out_tlast      // run_last
);

  logic [uwrap_pkg::CFG_W-1:0] line_width_r;
  logic            q_push, q_full, q_pop, q_valid;
  uwrap_pkg::tok_t push_tok, pop_tok;
  uwrap_pkg::res_t res;

  // line width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= uwrap_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      line_width_r <= cfg_wr_data;
    end
  end

  uwrap_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_fin   (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_tok    (push_tok)
  );

  uwrap_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop       (q_pop),
    .pop_tok   (pop_tok),
    .not_empty (q_valid)
  );

  uwrap_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .line_width (line_width_r),
    .q_valid    (q_valid),
    .q_tok      (pop_tok),
    .q_pop      (q_pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (res)
  );

  // result packing
  assign out_tdata = {5'b0, res.len, res.bytes};
  assign out_tuser = res.line_end;
  assign out_tlast = res.run_last;

endmodule

>>> design/uwrap_ram.sv
// generic single write port ram with registered read
// no dependencies

module uwrap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/uwrap_fifo.sv
// short token queue between the front end and the back end
// depends on uwrap_pkg (tok_t, FIFO_DEPTH)

module uwrap_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  uwrap_pkg::tok_t push_tok,
  output logic            full,
  input  logic            pop,
  output uwrap_pkg::tok_t pop_tok,
  output logic            not_empty
);

  localparam int DEPTH = uwrap_pkg::FIFO_DEPTH;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  uwrap_pkg::tok_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_tok   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

>>> design/uwrap_front.sv
// front end: accepts text bytes, gathers utf-8 characters, classifies bytes
// depends on uwrap_pkg (tok_t, act_t, character and lead byte constants)

module uwrap_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_fin,
  input  logic            q_full,
  output logic            q_push,
  output uwrap_pkg::tok_t q_tok
);

  logic [31:0] gather_r, gather_nxt;
  logic [2:0]  held_r, held_nxt;
  logic [1:0]  left_r, left_nxt;
  logic [31:0] shifted;
  logic [2:0]  lead_len;
  logic        take;

  // byte count announced by a lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if (b <= uwrap_pkg::LEAD1_MAX) begin
      n = 3'd1;
    end else if (b <= uwrap_pkg::LEAD2_MAX) begin
      n = 3'd2;
    end else if (b <= uwrap_pkg::LEAD3_MAX) begin
      n = 3'd3;
    end else if (b <= uwrap_pkg::LEAD4_MAX) begin
      n = 3'd4;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign shifted  = gather_r | ({24'b0, in_byte} << {held_r[1:0], 3'b000});
  assign lead_len = lead_length(in_byte);

  // classify the byte and build the token
  always_comb begin
    q_tok.ch_valid = 1'b0;
    q_tok.ch       = gather_r;
    q_tok.act      = uwrap_pkg::ACT_NONE;
    q_tok.fin      = in_fin;
    gather_nxt     = gather_r;
    held_nxt       = held_r;
    left_nxt       = left_r;
    if (in_byte == 8'h00) begin
      // zero byte: only the final mark counts
      q_tok.ch_valid = in_fin && (held_r != 3'd0);
    end else if (in_byte == uwrap_pkg::CHAR_SPACE ||
                 in_byte == uwrap_pkg::CHAR_NEWLINE) begin
      // space or newline ends a partial character
      q_tok.ch_valid = (held_r != 3'd0);
      q_tok.act      = (in_byte == uwrap_pkg::CHAR_SPACE) ? uwrap_pkg::ACT_SPACE
                                                          : uwrap_pkg::ACT_NEWL;
      gather_nxt     = '0;
      held_nxt       = '0;
      left_nxt       = '0;
    end else if (left_r != 2'd0) begin
      // continuation byte
      q_tok.ch = shifted;
      if (left_r == 2'd1 || in_fin) begin
        q_tok.ch_valid = 1'b1;
        gather_nxt     = '0;
        held_nxt       = '0;
        left_nxt       = '0;
      end else begin
        gather_nxt = shifted;
        held_nxt   = 3'(held_r + 1'b1);
        left_nxt   = 2'(left_r - 1'b1);
      end
    end else begin
      // lead byte
      q_tok.ch = {24'b0, in_byte};
      if (lead_len == 3'd1 || in_fin) begin
        q_tok.ch_valid = 1'b1;
      end else begin
        gather_nxt = {24'b0, in_byte};
        held_nxt   = 3'd1;
        left_nxt   = 2'(lead_len - 3'd1);
      end
    end
    // the last byte of the text always leaves the gather empty
    if (in_fin) begin
      gather_nxt = '0;
      held_nxt   = '0;
      left_nxt   = '0;
    end
  end

  // only bytes that ask something of the back end enter the queue
  assign q_push = take && (q_tok.ch_valid || (q_tok.act != uwrap_pkg::ACT_NONE) || in_fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r <= '0;
      held_r   <= '0;
      left_r   <= '0;
    end else if (take) begin
      gather_r <= gather_nxt;
      held_r   <= held_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

>>> design/uwrap_back.sv
// back end: word store, line filling sequencer and result output stage
// depends on uwrap_pkg (tok_t, res_t, act_t, CHAR_SPACE, CFG_W) and uwrap_ram

module uwrap_back #(
  parameter int MAX_WIDTH = uwrap_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [uwrap_pkg::CFG_W-1:0] line_width,
  input  logic                        q_valid,
  input  uwrap_pkg::tok_t             q_tok,
  output logic                        q_pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output uwrap_pkg::res_t             out_res
);

  localparam int IDX_W = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ADD   = 9'b000000010,
    S_ADDCL = 9'b000000100,
    S_FLUSH = 9'b000001000,
    S_EMIT  = 9'b000010000,
    S_SPACE = 9'b000100000,
    S_NEWL  = 9'b001000000,
    S_FINC  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  // where a word flush goes on to
  typedef enum logic [2:0] {
    PH_SPACE = 3'b001,
    PH_NEWL  = 3'b010,
    PH_FIN   = 3'b100
  } phase_t;

  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  uwrap_pkg::tok_t tok_r, tok_nxt;
  logic [CNT_W-1:0] word_r, word_nxt;
  logic [CNT_W-1:0] line_r, line_nxt;
  logic            content_r, content_nxt;
  logic            skip_r, skip_nxt;
  logic            ret_add_r, ret_add_nxt;
  logic [IDX_W-1:0] a_r, a_nxt;

  logic            pend_valid_r, pend_valid_nxt;
  uwrap_pkg::res_t pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  uwrap_pkg::res_t out_r, out_nxt;

  logic [CNT_W-1:0] w;
  logic [SUM_W-1:0] w_ext, lw_sum, lw1_sum;
  logic             out_free, can_emit;
  logic             emit_req, emit_end, done_load, out_load;
  logic [31:0]      emit_bytes;
  logic [2:0]       emit_len;
  logic             ram_we;
  logic [31:0]      ram_rdata;

  // byte count of a stored character: highest nonzero byte
  function automatic logic [2:0] char_len_of(input logic [31:0] bytes);
    logic [2:0] n;
    if (bytes[31:24] != 8'h00) begin
      n = 3'd4;
    end else if (bytes[23:16] != 8'h00) begin
      n = 3'd3;
    end else if (bytes[15:8] != 8'h00) begin
      n = 3'd2;
    end else if (bytes[7:0] != 8'h00) begin
      n = 3'd1;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  // next step for a token once its character, if any, is stored
  function automatic state_t disp_state(input uwrap_pkg::act_t act, input logic fin);
    state_t s;
    if (act != uwrap_pkg::ACT_NONE || fin) begin
      s = S_FLUSH;
    end else begin
      s = S_DONE;
    end
    return s;
  endfunction

  function automatic phase_t disp_phase(input uwrap_pkg::act_t act);
    phase_t p;
    unique case (act)
      uwrap_pkg::ACT_SPACE: p = PH_SPACE;
      uwrap_pkg::ACT_NEWL:  p = PH_NEWL;
      default:              p = PH_FIN;
    endcase
    return p;
  endfunction

  function automatic state_t phase_target(input phase_t p);
    state_t s;
    unique case (p)
      PH_SPACE: s = S_SPACE;
      PH_NEWL:  s = S_NEWL;
      default:  s = S_FINC;
    endcase
    return s;
  endfunction

  // effective width: zero acts as one, clipped to the store depth
  always_comb begin
    if (line_width == '0) begin
      w = CNT_W'(1);
    end else if (line_width > uwrap_pkg::CFG_W'(MAX_WIDTH)) begin
      w = CNT_W'(MAX_WIDTH);
    end else begin
      w = CNT_W'(line_width);
    end
  end

  assign w_ext   = {1'b0, w};
  assign lw_sum  = {1'b0, line_r} + {1'b0, word_r};
  assign lw1_sum = SUM_W'(lw_sum + 1'b1);

  assign out_free = !out_valid_r || out_ready;
  assign can_emit = !pend_valid_r || out_free;

  // word store
  uwrap_ram #(
    .WIDTH (32),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_r[IDX_W-1:0]),
    .wdata (tok_r.ch),
    .raddr (a_nxt),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    tok_nxt     = tok_r;
    word_nxt    = word_r;
    line_nxt    = line_r;
    content_nxt = content_r;
    skip_nxt    = skip_r;
    ret_add_nxt = ret_add_r;
    a_nxt       = '0;
    ram_we      = 1'b0;
    q_pop       = 1'b0;
    emit_req    = 1'b0;
    emit_bytes  = '0;
    emit_len    = '0;
    emit_end    = 1'b0;
    done_load   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          tok_nxt = q_tok;
          if (q_tok.ch_valid) begin
            state_nxt = S_ADD;
          end else begin
            state_nxt = disp_state(q_tok.act, q_tok.fin);
            phase_nxt = disp_phase(q_tok.act);
          end
        end
      end

      // add one character to the pending word
      S_ADD: begin
        if (line_r != '0 && lw1_sum > w_ext) begin
          // word no longer fits: close the line, then look again
          if (can_emit) begin
            emit_req    = 1'b1;
            emit_end    = 1'b1;
            line_nxt    = '0;
            content_nxt = 1'b0;
            skip_nxt    = 1'b0;
          end
        end else if (word_r >= w) begin
          // word fills a whole line: cut it here
          state_nxt   = S_EMIT;
          ret_add_nxt = 1'b1;
        end else begin
          ram_we      = 1'b1;
          word_nxt    = CNT_W'(word_r + 1'b1);
          content_nxt = 1'b1;
          state_nxt   = disp_state(tok_r.act, tok_r.fin);
          phase_nxt   = disp_phase(tok_r.act);
        end
      end

      // close after a cut word, then store the character
      S_ADDCL: begin
        if (can_emit) begin
          emit_req    = 1'b1;
          emit_end    = 1'b1;
          line_nxt    = '0;
          skip_nxt    = 1'b0;
          ram_we      = 1'b1;
          word_nxt    = CNT_W'(word_r + 1'b1);
          content_nxt = 1'b1;
          state_nxt   = disp_state(tok_r.act, tok_r.fin);
          phase_nxt   = disp_phase(tok_r.act);
        end
      end

      // release the pending word onto the line
      S_FLUSH: begin
        if (word_r == '0) begin
          state_nxt = phase_target(phase_r);
        end else if (line_r != '0 && lw_sum > w_ext) begin
          if (can_emit) begin
            emit_req    = 1'b1;
            emit_end    = 1'b1;
            line_nxt    = '0;
            content_nxt = 1'b0;
            skip_nxt    = 1'b0;
          end
        end else begin
          state_nxt   = S_EMIT;
          ret_add_nxt = 1'b0;
        end
      end

      // stream the stored characters, one per cycle while the output can take them
      S_EMIT: begin
        a_nxt = a_r;
        if (can_emit) begin
          emit_req   = 1'b1;
          emit_bytes = ram_rdata;
          emit_len   = char_len_of(ram_rdata);
          if (CNT_W'(a_r) == CNT_W'(word_r - 1'b1)) begin
            a_nxt    = '0;
            line_nxt = CNT_W'(lw_sum);
            word_nxt = '0;
            if (ret_add_r) begin
              state_nxt = S_ADDCL;
            end else begin
              content_nxt = 1'b1;
              if (lw_sum >= w_ext) begin
                skip_nxt = 1'b1;
              end
              state_nxt = phase_target(phase_r);
            end
          end else begin
            a_nxt = IDX_W'(a_r + 1'b1);
          end
        end
      end

      S_SPACE: begin
        if (skip_r || can_emit) begin
          if (!skip_r) begin
            emit_req    = 1'b1;
            emit_bytes  = {24'b0, uwrap_pkg::CHAR_SPACE};
            emit_len    = 3'd1;
            line_nxt    = CNT_W'(line_r + 1'b1);
            content_nxt = 1'b1;
            if ({1'b0, line_r} + 1'b1 >= w_ext) begin
              skip_nxt = 1'b1;
            end
          end
          state_nxt = tok_r.fin ? S_FLUSH : S_DONE;
          phase_nxt = PH_FIN;
        end
      end

      S_NEWL: begin
        if (can_emit) begin
          emit_req    = 1'b1;
          emit_end    = 1'b1;
          line_nxt    = '0;
          content_nxt = 1'b0;
          skip_nxt    = 1'b0;
          state_nxt   = tok_r.fin ? S_FLUSH : S_DONE;
          phase_nxt   = PH_FIN;
        end
      end

      // end of text: close an open line
      S_FINC: begin
        if (!content_r) begin
          state_nxt = S_DONE;
        end else if (can_emit) begin
          emit_req    = 1'b1;
          emit_end    = 1'b1;
          line_nxt    = '0;
          content_nxt = 1'b0;
          skip_nxt    = 1'b0;
          state_nxt   = S_DONE;
        end
      end

      // hand over the held result marked as the last of its byte
      S_DONE: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          done_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // held result and output register
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_load       = 1'b0;
    out_nxt        = out_r;
    if (emit_req) begin
      pend_valid_nxt    = 1'b1;
      pend_nxt.bytes    = emit_bytes;
      pend_nxt.len      = emit_len;
      pend_nxt.line_end = emit_end;
      pend_nxt.run_last = 1'b0;
      out_load          = pend_valid_r;
    end
    if (done_load) begin
      pend_valid_nxt = 1'b0;
      out_load       = 1'b1;
    end
    if (out_load) begin
      out_nxt          = pend_r;
      out_nxt.run_last = done_load;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_FIN;
      word_r       <= '0;
      line_r       <= '0;
      content_r    <= 1'b0;
      skip_r       <= 1'b0;
      ret_add_r    <= 1'b0;
      a_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      word_r       <= word_nxt;
      line_r       <= line_nxt;
      content_r    <= content_nxt;
      skip_r       <= skip_nxt;
      ret_add_r    <= ret_add_nxt;
      a_r          <= a_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // checks
  a_emit_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (CNT_W'(a_r) < word_r))
    else $error("word store read beyond the pending word");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_valid_r)
    else $error("held result left over between transactions");

  a_word_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_r <= CNT_W'(MAX_WIDTH))
    else $error("pending word exceeds the store depth");

  a_mark_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.line_end) |-> (out_r.len == 3'd0 && out_r.bytes == 32'd0))
    else $error("line-end mark carries character data");

endmodule
